// ----- hdl/running_median_tracker_core_macros.svh -----
// assertion macros used by the checker file of the running median tracker
`ifndef RUNNING_MEDIAN_TRACKER_CORE_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk and quiet during reset
`define RMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk and quiet during reset
`define RMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rmt_pkg.sv -----
// shared types and cell operation codes for the running median tracker
package rmt_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [1:0] cell_op_t;

	localparam cell_op_t OP_HOLD   = 2'd0;
	localparam cell_op_t OP_INSERT = 2'd1;
	localparam cell_op_t OP_PUSH   = 2'd2;
	localparam cell_op_t OP_REMINS = 2'd3;

	typedef struct packed {
		cell_op_t op;
		sample_t  v;
		sample_t  push_val;
	} cell_ctrl_t;

endpackage

// ----- hdl/running_median_tracker_core.sv -----
// running median tracker: two cell rows holding the lower and upper halves of the store
// Takes one signed sample per beat and returns, one beat per sample, the median of every
// sample kept so far, the number kept and a dropped flag. The store is split over two rows
// of cells: the lower half in descending order and the upper half in ascending order, so the
// largest low entry and the smallest high entry always sit in the first cell of each row.
// Each sample is sorted into one row, with at most one entry moving across the middle, so
// the block takes a new sample every cycle unless sample_stall holds it off while a stalled
// result waits; results pass row update, then median and output register. Once DEPTH
// samples are held, more samples are discarded with dropped set and the median repeats. The
// store needs no clearing after reset: only entries below the row counts are ever used.
module running_median_tracker_core #(
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic signed [15:0]           sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [15:0]           median,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         dropped
);

	localparam int NL = (DEPTH + 1) / 2;
	localparam int NU = DEPTH / 2;
	localparam int LW = $clog2(NL + 1);
	localparam int UW = $clog2(NU + 1);
	localparam int CW = $clog2(DEPTH + 1);

	logic [LW-1:0] cl_q;
	logic [UW-1:0] cu_q;
	rmt_pkg::cell_ctrl_t lctrl;
	rmt_pkg::cell_ctrl_t uctrl;
	rmt_pkg::sample_t lh;
	rmt_pkg::sample_t uh;

	logic          s1_valid_q;
	logic          dropped_s1;
	logic [CW-1:0] count_s1;

	logic          result_valid_q;
	rmt_pkg::sample_t median_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;

	logic          go;
	logic          adv;
	logic [CW-1:0] n;
	logic          full;
	logic          bal;
	logic          odd;
	logic signed [16:0] sum;
	logic signed [16:0] sum_adj;
	rmt_pkg::sample_t med;

	assign n    = CW'(cl_q) + CW'(cu_q);
	assign full = n == CW'(DEPTH);
	assign bal  = cl_q == LW'(cu_q);

	assign adv          = !result_valid_q || !result_stall;
	assign sample_stall = s1_valid_q && !adv;
	assign go           = sample_valid && !sample_stall;

	// steer the sample into one row, moving a head across when that keeps the halves even
	always_comb begin
		lctrl.op       = rmt_pkg::OP_HOLD;
		lctrl.v        = sample;
		lctrl.push_val = uh;
		uctrl.op       = rmt_pkg::OP_HOLD;
		uctrl.v        = sample;
		uctrl.push_val = lh;
		if (go && !full) begin
			if (bal) begin
				if (cu_q == '0 || sample <= uh) begin
					lctrl.op = rmt_pkg::OP_INSERT;
				end else begin
					lctrl.op = rmt_pkg::OP_PUSH;
					uctrl.op = rmt_pkg::OP_REMINS;
				end
			end else begin
				if (sample >= lh) begin
					uctrl.op = rmt_pkg::OP_INSERT;
				end else begin
					uctrl.op = rmt_pkg::OP_PUSH;
					lctrl.op = rmt_pkg::OP_REMINS;
				end
			end
		end
	end

	rmt_heap #(
		.N    (NL),
		.DESC (1'b1)
	) u_low (
		.clk  (clk),
		.ctrl (lctrl),
		.cnt  (cl_q),
		.head (lh)
	);

	rmt_heap #(
		.N    (NU),
		.DESC (1'b0)
	) u_high (
		.clk  (clk),
		.ctrl (uctrl),
		.cnt  (cu_q),
		.head (uh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q <= '0;
			cu_q <= '0;
		end else if (go && !full) begin
			if (bal) begin
				cl_q <= cl_q + LW'(1);
			end else begin
				cu_q <= cu_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (go) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dropped_s1 <= full;
			count_s1   <= full ? n : n + CW'(1);
		end
	end

	// halve toward zero: bias negative sums by one before the shift
	assign odd     = !bal;
	assign sum     = {lh[15], lh} + {uh[15], uh};
	assign sum_adj = sum + {16'b0, sum[16]};
	assign med     = odd ? lh : sum_adj[16:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			median_q  <= med;
			count_q   <= count_s1;
			dropped_q <= dropped_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign median       = median_q;
	assign count        = count_q;
	assign dropped      = dropped_q;

endmodule

// ----- hdl/rmt_cell.sv -----
// one cell of a sorted heap row: holds one entry and shifts with its neighbors
module rmt_cell #(
	parameter bit DESC = 1'b0
) (
	input  logic               clk,
	input  rmt_pkg::cell_ctrl_t ctrl,
	input  logic               first,
	input  logic               valid_self,
	input  logic               valid_next,
	input  rmt_pkg::sample_t   prev_val,
	input  logic               prev_ahead,
	input  rmt_pkg::sample_t   next_val,
	input  logic               next_ahead,
	output rmt_pkg::sample_t   val,
	output logic               ahead
);

	rmt_pkg::sample_t val_q;
	rmt_pkg::sample_t nxt;
	rmt_pkg::sample_t v;

	assign v      = ctrl.v;
	assign val    = val_q;
	// entry sorts ahead of the incoming sample
	assign ahead  = DESC ? ($signed(val_q) >= $signed(v)) : ($signed(val_q) <= $signed(v));

	always_comb begin
		case (ctrl.op)
			rmt_pkg::OP_INSERT: begin
				if (valid_self && ahead) begin
					nxt = val_q;
				end else if (first || prev_ahead) begin
					nxt = v;
				end else begin
					nxt = prev_val;
				end
			end
			rmt_pkg::OP_PUSH: begin
				nxt = first ? ctrl.push_val : prev_val;
			end
			rmt_pkg::OP_REMINS: begin
				if (valid_next && next_ahead) begin
					nxt = next_val;
				end else if (first || ahead) begin
					nxt = v;
				end else begin
					nxt = val_q;
				end
			end
			default: begin
				nxt = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

endmodule

// ----- hdl/rmt_heap.sv -----
// row of cells holding one half of the sorted store, head at cell zero
module rmt_heap #(
	parameter int N    = 128,
	parameter bit DESC = 1'b0
) (
	input  logic                      clk,
	input  rmt_pkg::cell_ctrl_t       ctrl,
	input  logic [$clog2(N+1)-1:0]    cnt,
	output rmt_pkg::sample_t          head
);

	localparam int CW = $clog2(N + 1);

	rmt_pkg::sample_t vals [N];
	logic             aheads [N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			rmt_pkg::sample_t prev_val;
			logic             prev_ahead;
			rmt_pkg::sample_t next_val;
			logic             next_ahead;
			logic             valid_next;

			if (i == 0) begin : g_first
				assign prev_val   = '0;
				assign prev_ahead = 1'b0;
			end else begin : g_mid
				assign prev_val   = vals[i-1];
				assign prev_ahead = aheads[i-1];
			end

			if (i == N - 1) begin : g_last
				assign next_val   = '0;
				assign next_ahead = 1'b0;
				assign valid_next = 1'b0;
			end else begin : g_inner
				assign next_val   = vals[i+1];
				assign next_ahead = aheads[i+1];
				assign valid_next = cnt > CW'(i + 1);
			end

			rmt_cell #(
				.DESC (DESC)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.first      ((i == 0) ? 1'b1 : 1'b0),
				.valid_self (cnt > CW'(i)),
				.valid_next (valid_next),
				.prev_val   (prev_val),
				.prev_ahead (prev_ahead),
				.next_val   (next_val),
				.next_ahead (next_ahead),
				.val        (vals[i]),
				.ahead      (aheads[i])
			);
		end
	endgenerate

	assign head = vals[0];

endmodule

// ----- hdl/rmt_checker.sv -----
// port checker for the running median tracker and its bind
`include "running_median_tracker_core_macros.svh"

module rmt_checker #(
	parameter int DEPTH = 256
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         sample_stall,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic signed [15:0]           median,
	input logic [$clog2(DEPTH+1)-1:0]   count,
	input logic                         dropped
);

	localparam int CW = $clog2(DEPTH + 1);

	`RMT_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid,
		"stalled result beat withdrawn")
	`RMT_ASSERT_NEXT(a_result_stable, result_valid && result_stall,
		$stable(median) && $stable(count) && $stable(dropped), "stalled result beat changed")
	`RMT_ASSERT_NOW(a_drop_when_full, result_valid && dropped, count == CW'(DEPTH),
		"sample dropped while store not full")
	`RMT_ASSERT_NOW(a_count_nonzero, result_valid, count != '0, "result with empty store")
	`RMT_ASSERT_NOW(a_stall_only_blocked, sample_stall, result_valid && result_stall,
		"input stalled while output free")

endmodule

bind running_median_tracker_core rmt_checker #(
	.DEPTH (DEPTH)
) u_rmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.median       (median),
	.count        (count),
	.dropped      (dropped)
);
